>>> rtl/xoshiro_pkg.sv
// ----------------------------------------------------------------------------
// xoshiro_pkg: shared types and constants of the xoshiro256 generator
// Action codes, the register index, the splitmix64 and jump constants, and
// the command and status types between the controller and the datapath.
// ----------------------------------------------------------------------------
package xoshiro_pkg;

  // Action codes carried by an input item.
  localparam logic [1:0] ACT_NEXT = 2'd0;
  localparam logic [1:0] ACT_SEED = 2'd1;
  localparam logic [1:0] ACT_JUMP = 2'd2;

  // Register index of the scrambler mode.
  localparam logic REG_SCRAMBLER_MODE = 1'b0;

  // Scrambler mode codes.
  localparam logic MODE_STARSTAR = 1'b0;
  localparam logic MODE_PLUSPLUS = 1'b1;

  // splitmix64 constants.
  localparam logic [63:0] SPLITMIX_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A      = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B      = 64'h94d049bb133111eb;

  // Jump polynomial; bit n is bit (n mod 64) of word (n / 64).
  localparam logic [255:0] JUMP_POLY = {
    64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
    64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
  };

  typedef enum logic [3:0] {
    OP_NONE,
    OP_NEXT,
    OP_SEED_LOAD,
    OP_MIX_ADD,
    OP_MUL_LO,
    OP_MUL_CROSS_A,
    OP_MUL_CROSS_B,
    OP_MIX_FOLD,
    OP_STORE,
    OP_JUMP_STEP
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       mul_sel;    // 0: first splitmix multiplier, 1: second
    logic [1:0] word_idx;   // state word written by a store
    logic [7:0] jump_step;  // selects the jump polynomial bit
    logic       jump_last;  // final jump step: the accumulator becomes the state
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_ready;       // the output pipeline can take a next item
  } dp_status_t;

endpackage

>>> rtl/xoshiro256_generator.sv
// ----------------------------------------------------------------------------
// xoshiro256_generator: xoshiro256 pseudo-random generator, top level
// Configuration register, sequencer and datapath of the generator.
// ----------------------------------------------------------------------------
// A next item is accepted every cycle while the sequencer is idle and the
// pipeline can take it, and its random value comes out of a two-stage scrambler
// pipeline that keeps streaming while the output side is stalled, until both
// stages are full. A seed item occupies the block for four splitmix64 steps,
// all run on the single 32x32 multiplier that builds each 64-bit product in
// three passes. A jump item occupies it one polynomial step per cycle. The
// state resets to all zeros and must be seeded before values are useful.
// Register 0 at byte address 0 selects the scrambler: 0 starstar, 1 plusplus.
module xoshiro256_generator
  import xoshiro_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [63:0] seed_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] random_value_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       mode_q;
  dp_cmd_t    cmd;
  dp_status_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_STARSTAR;
    end else if (psel && penable && pwrite && (paddr[2] == REG_SCRAMBLER_MODE)) begin
      mode_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_SCRAMBLER_MODE) ? {31'd0, mode_q} : 32'd0;

  xoshiro_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  xoshiro_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .scrambler_mode_i (mode_q),
    .seed_value_i     (seed_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .random_value_o   (random_value_o)
  );

endmodule

>>> rtl/xoshiro_ctrl.sv
// ----------------------------------------------------------------------------
// xoshiro_ctrl: action sequencer of the xoshiro256 generator
// Accepts input items and steps the datapath through the seed and jump
// sequences.
// ----------------------------------------------------------------------------
module xoshiro_ctrl
  import xoshiro_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] action_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX_ADD,
    ST_MUL_LO,
    ST_MUL_CROSS_A,
    ST_MUL_CROSS_B,
    ST_MIX_FOLD,
    ST_STORE,
    ST_JUMP
  } state_e;

  state_e     state_q;
  logic [1:0] word_q;
  logic       pass_q;
  logic [7:0] step_q;
  logic       accept;

  assign in_stall_o = !((state_q == ST_IDLE) && status_i.pipe_ready);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = OP_NONE;
    cmd_o.mul_sel   = pass_q;
    cmd_o.word_idx  = word_q;
    cmd_o.jump_step = step_q;
    cmd_o.jump_last = (step_q == 8'hff);
    case (state_q)
      ST_IDLE: begin
        if (accept && (action_i == ACT_NEXT)) begin
          cmd_o.op = OP_NEXT;
        end else if (accept && (action_i == ACT_SEED)) begin
          cmd_o.op = OP_SEED_LOAD;
        end
      end
      ST_MIX_ADD:     cmd_o.op = OP_MIX_ADD;
      ST_MUL_LO:      cmd_o.op = OP_MUL_LO;
      ST_MUL_CROSS_A: cmd_o.op = OP_MUL_CROSS_A;
      ST_MUL_CROSS_B: cmd_o.op = OP_MUL_CROSS_B;
      ST_MIX_FOLD:    cmd_o.op = OP_MIX_FOLD;
      ST_STORE:       cmd_o.op = OP_STORE;
      ST_JUMP:        cmd_o.op = OP_JUMP_STEP;
      default:        cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      word_q  <= 2'd0;
      pass_q  <= 1'b0;
      step_q  <= 8'd0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && (action_i == ACT_SEED)) begin
            state_q <= ST_MIX_ADD;
            word_q  <= 2'd0;
            pass_q  <= 1'b0;
          end else if (accept && (action_i == ACT_JUMP)) begin
            state_q <= ST_JUMP;
            step_q  <= 8'd0;
          end
        end
        ST_MIX_ADD:     state_q <= ST_MUL_LO;
        ST_MUL_LO:      state_q <= ST_MUL_CROSS_A;
        ST_MUL_CROSS_A: state_q <= ST_MUL_CROSS_B;
        ST_MUL_CROSS_B: begin
          state_q <= pass_q ? ST_STORE : ST_MIX_FOLD;
        end
        ST_MIX_FOLD: begin
          pass_q  <= 1'b1;
          state_q <= ST_MUL_LO;
        end
        ST_STORE: begin
          pass_q <= 1'b0;
          word_q <= word_q + 2'd1;
          if (word_q == 2'd3) begin
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_MIX_ADD;
          end
        end
        ST_JUMP: begin
          step_q <= step_q + 8'd1;
          if (step_q == 8'hff) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // No item may enter while a seed or jump sequence runs.
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("item accepted while a sequence is running");

  // A jump always starts from step zero, so the counter rests at zero.
  a_step_rests: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (step_q == 8'd0))
    else $error("jump step count not at zero while idle");

  // A seed sequence always writes all four words before going idle.
  a_word_rests: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ((word_q == 2'd0) && !pass_q))
    else $error("seed word counter not at zero while idle");

  // The last jump step returns the sequencer to idle.
  a_jump_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_JUMP) && (step_q == 8'hff)) |=> (state_q == ST_IDLE))
    else $error("jump did not end after its last step");
`endif

endmodule

>>> rtl/xoshiro_dp.sv
// ----------------------------------------------------------------------------
// xoshiro_dp: datapath of the xoshiro256 generator
// Holds the state words, the jump accumulator, the splitmix64 unit with a
// shared 32x32 multiplier, and the two-stage output scrambler pipeline.
// ----------------------------------------------------------------------------
module xoshiro_dp
  import xoshiro_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  status_o,
  input  logic        scrambler_mode_i,
  input  logic [63:0] seed_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] random_value_o
);

  function automatic logic [3:0][63:0] xo_advance(input logic [3:0][63:0] w);
    logic [63:0]      t;
    logic [3:0][63:0] r;
    t = {w[1][46:0], 17'd0};
    r = w;
    r[2] = r[2] ^ r[0];
    r[3] = r[3] ^ r[1];
    r[1] = r[1] ^ r[2];
    r[0] = r[0] ^ r[3];
    r[2] = r[2] ^ t;
    r[3] = {r[3][18:0], r[3][63:19]};
    return r;
  endfunction

  logic [3:0][63:0] gen_q, gen_d;
  logic [3:0][63:0] jacc_q, jacc_d;
  logic [3:0][63:0] jacc_new;
  logic [63:0]      mix_q, mix_sum;
  logic [63:0]      opnd_q, prod_q;
  logic [63:0]      mul_const;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_res;

  logic             s1_v_q, s1_mode_q;
  logic [63:0]      s1_a_q, s1_b_q;
  logic [63:0]      times5, pp_sum;
  logic             out_v_q;
  logic [63:0]      out_q;
  logic             s2_ready, s1_move;

  // ---------------- state words and jump ----------------
  assign jacc_new = JUMP_POLY[cmd_i.jump_step] ? (jacc_q ^ gen_q) : jacc_q;

  always_comb begin
    gen_d  = gen_q;
    jacc_d = jacc_q;
    case (cmd_i.op)
      OP_NEXT: gen_d = xo_advance(gen_q);
      OP_STORE: gen_d[cmd_i.word_idx] = prod_q ^ {31'd0, prod_q[63:31]};
      OP_JUMP_STEP: begin
        if (cmd_i.jump_last) begin
          gen_d  = jacc_new;
          jacc_d = '0;
        end else begin
          gen_d  = xo_advance(gen_q);
          jacc_d = jacc_new;
        end
      end
      default: gen_d = gen_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q  <= '0;
      jacc_q <= '0;
    end else begin
      gen_q  <= gen_d;
      jacc_q <= jacc_d;
    end
  end

  // ---------------- splitmix64 unit ----------------
  // The low 64 bits of each product are built from three 32x32 partial products,
  // one per cycle.
  assign mix_sum   = mix_q + SPLITMIX_GAMMA;
  assign mul_const = cmd_i.mul_sel ? MIX_MUL_B : MIX_MUL_A;

  always_comb begin
    case (cmd_i.op)
      OP_MUL_CROSS_A: begin
        mul_a = opnd_q[31:0];
        mul_b = mul_const[63:32];
      end
      OP_MUL_CROSS_B: begin
        mul_a = opnd_q[63:32];
        mul_b = mul_const[31:0];
      end
      default: begin
        mul_a = opnd_q[31:0];
        mul_b = mul_const[31:0];
      end
    endcase
  end

  assign mul_res = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_SEED_LOAD: mix_q <= seed_value_i;
      OP_MIX_ADD: begin
        mix_q  <= mix_sum;
        opnd_q <= mix_sum ^ {30'd0, mix_sum[63:30]};
      end
      OP_MUL_LO: prod_q <= mul_res;
      OP_MUL_CROSS_A, OP_MUL_CROSS_B: begin
        prod_q <= {prod_q[63:32] + mul_res[31:0], prod_q[31:0]};
      end
      OP_MIX_FOLD: opnd_q <= prod_q ^ {27'd0, prod_q[63:27]};
      default: mix_q <= mix_q;
    endcase
  end

  // ---------------- output scrambler pipeline ----------------
  assign s2_ready            = !out_v_q || !out_stall_i;
  assign s1_move             = s1_v_q && s2_ready;
  assign status_o.pipe_ready = !s1_v_q || s2_ready;

  assign times5 = gen_q[1] + {gen_q[1][61:0], 2'b00};
  assign pp_sum = gen_q[0] + gen_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_NEXT) begin
        s1_v_q <= 1'b1;
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
      if (s2_ready) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_NEXT) begin
      s1_mode_q <= scrambler_mode_i;
      if (scrambler_mode_i == MODE_PLUSPLUS) begin
        s1_a_q <= {pp_sum[40:0], pp_sum[63:41]};
      end else begin
        s1_a_q <= {times5[56:0], times5[63:57]};
      end
      s1_b_q <= gen_q[0];
    end
    if (s1_move) begin
      if (s1_mode_q == MODE_PLUSPLUS) begin
        out_q <= s1_a_q + s1_b_q;
      end else begin
        out_q <= s1_a_q + {s1_a_q[60:0], 3'b000};
      end
    end
  end

  assign out_valid_o    = out_v_q;
  assign random_value_o = out_q;

endmodule
